>>> rtl/shaded_line_rasterizer_unit_assert.svh
// Assertion macros for the shaded line rasterizer checker.
// No dependencies; included by the checker file only.
`ifndef SHADED_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define SHADED_LINE_RASTERIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define SLR_ASSERT_IMPL(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLR_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/slr_pkg.sv
// Shared types and codes for the shaded line rasterizer.
// No dependencies.
package slr_pkg;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef struct packed {
    logic dir_x_neg;
    logic dir_y_neg;
    logic x_is_major;
  } line_dir_t;

endpackage

>>> rtl/shaded_line_rasterizer_unit.sv
// Shaded line rasterizer top level: input register, line state, result register.
// Depends on slr_pkg, slr_setup and slr_step.
//
//  channel | dir | tdata (low bit up)                         | tuser      | tlast
//  s_*     | in  | start_x, start_y, start_z, end_x, end_y    | action     | -
//  m_*     | out | pixel_x, pixel_y, shade_base, shade_ramp    | valid_res  | last
//
// One item per clock sustained while m_tready stays high; an accepted item passes the
// input register, then the line state update and the result register.
// Every accepted item gives exactly one result item.
// rst (synchronous) drops any held items and ends the active line.
// A stalled result holds; one more item is taken into the input register meanwhile.
module shaded_line_rasterizer_unit #(
  parameter int COORD_BITS  = 12,
  parameter int HEIGHT_BITS = 16,
  localparam int IN_W        = 4*COORD_BITS + HEIGHT_BITS,
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
  localparam int RAMP_BITS   = ((HEIGHT_BITS > 2*COORD_BITS) ? HEIGHT_BITS : 2*COORD_BITS) + 2,
  localparam int OUT_W       = 2*COORD_BITS + HEIGHT_BITS + RAMP_BITS,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // start_x, start_y, start_z, end_x, end_y
  input  logic                   s_tuser,   // action
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // pixel_x, pixel_y, shade_base, shade_ramp
  output logic                   m_tuser,   // valid_res
  output logic                   m_tlast    // last
);
  import slr_pkg::*;

  localparam int SY_LO = COORD_BITS;
  localparam int SZ_LO = 2*COORD_BITS;
  localparam int EX_LO = 2*COORD_BITS + HEIGHT_BITS;
  localparam int EY_LO = 3*COORD_BITS + HEIGHT_BITS;
  localparam int RACC_BITS = 2*COORD_BITS;

  // input register
  logic                          in_valid;
  action_t                       in_action;
  logic signed [COORD_BITS-1:0]  in_sx, in_sy, in_ex, in_ey;
  logic signed [HEIGHT_BITS-1:0] in_sz;

  // line state
  logic [COORD_BITS-1:0]  cur_x, cur_y;
  logic [HEIGHT_BITS-1:0] height;
  logic [COORD_BITS-1:0]  major_len, minor_len;
  line_dir_t              dir;
  logic [COORD_BITS:0]    error_acc;
  logic [COORD_BITS-1:0]  step_index;
  logic [RACC_BITS-1:0]   ramp_acc;
  logic                   active;

  logic advance;
  logic s_accept;

  logic [COORD_BITS-1:0] setup_major, setup_minor;
  line_dir_t             setup_dir;
  logic [COORD_BITS-1:0] next_x, next_y;
  logic [COORD_BITS:0]   next_err;
  logic [COORD_BITS-1:0] step_index_next;
  logic                  step_last;

  logic signed [HEIGHT_BITS-1:0] base_sel;
  logic        [RACC_BITS-1:0]   off_sel;
  logic signed [RAMP_BITS-1:0]   ramp_val;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  slr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .start_x   (in_sx),
    .start_y   (in_sy),
    .end_x     (in_ex),
    .end_y     (in_ey),
    .major_len (setup_major),
    .minor_len (setup_minor),
    .dir       (setup_dir)
  );

  slr_step #(.COORD_BITS(COORD_BITS)) u_step (
    .cur_x     (cur_x),
    .cur_y     (cur_y),
    .major_len (major_len),
    .minor_len (minor_len),
    .error_acc (error_acc),
    .dir       (dir),
    .next_x    (next_x),
    .next_y    (next_y),
    .next_err  (next_err)
  );

  assign step_index_next = step_index + 1'b1;
  assign step_last       = step_index_next == major_len;

  // one shared adder: start pixel ramp is height + 1, steps use the accumulator
  assign base_sel = (in_action == ACT_START) ? in_sz : $signed(height);
  assign off_sel  = (in_action == ACT_START) ? RACC_BITS'(1) : ramp_acc;
  assign ramp_val = RAMP_BITS'(base_sel) + $signed(RAMP_BITS'(off_sel));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_accept) begin
      in_action <= action_t'(s_tuser);
      in_sx     <= s_tdata[SY_LO-1:0];
      in_sy     <= s_tdata[SZ_LO-1:SY_LO];
      in_sz     <= s_tdata[EX_LO-1:SZ_LO];
      in_ex     <= s_tdata[EY_LO-1:EX_LO];
      in_ey     <= s_tdata[IN_W-1:EY_LO];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (advance) begin
        if (in_action == ACT_START) begin
          active <= setup_major != '0;
        end else if (active && step_last) begin
          active <= 1'b0;
        end
      end
    end

    if (advance) begin
      if (in_action == ACT_START) begin
        cur_x      <= in_sx;
        cur_y      <= in_sy;
        height     <= in_sz;
        major_len  <= setup_major;
        minor_len  <= setup_minor;
        dir        <= setup_dir;
        error_acc  <= {1'b0, setup_minor};
        step_index <= '0;
        ramp_acc   <= '0;
        m_tdata    <= OUT_TDATA_W'({ramp_val, in_sz, in_sy, in_sx});
        m_tuser    <= 1'b1;
        m_tlast    <= setup_major == '0;
      end else if (active) begin
        cur_x      <= next_x;
        cur_y      <= next_y;
        error_acc  <= next_err;
        step_index <= step_index_next;
        ramp_acc   <= ramp_acc + RACC_BITS'(major_len);
        m_tdata    <= OUT_TDATA_W'({ramp_val, height, next_y, next_x});
        m_tuser    <= 1'b1;
        m_tlast    <= step_last;
      end else begin
        // step with no line: empty result
        m_tdata <= '0;
        m_tuser <= 1'b0;
        m_tlast <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/slr_setup.sv
// Line setup: absolute deltas, major/minor lengths and step directions.
// Depends on slr_pkg.
module slr_setup #(
  parameter int COORD_BITS = 12
) (
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic        [COORD_BITS-1:0] major_len,
  output logic        [COORD_BITS-1:0] minor_len,
  output slr_pkg::line_dir_t           dir
);
  import slr_pkg::*;

  logic signed [COORD_BITS:0] dx, dy;
  logic        [COORD_BITS:0] ax_full, ay_full;
  logic        [COORD_BITS-1:0] ax, ay;

  assign dx = (COORD_BITS+1)'(end_x) - (COORD_BITS+1)'(start_x);
  assign dy = (COORD_BITS+1)'(end_y) - (COORD_BITS+1)'(start_y);

  assign ax_full = dx[COORD_BITS] ? -dx : dx;
  assign ay_full = dy[COORD_BITS] ? -dy : dy;
  // magnitude never exceeds 2^COORD_BITS - 1
  assign ax = ax_full[COORD_BITS-1:0];
  assign ay = ay_full[COORD_BITS-1:0];

  always_comb begin
    dir.dir_x_neg  = dx[COORD_BITS] || (dx == '0);
    dir.dir_y_neg  = dy[COORD_BITS] || (dy == '0);
    dir.x_is_major = ax > ay;    // ties go along y
    major_len      = dir.x_is_major ? ax : ay;
    minor_len      = dir.x_is_major ? ay : ax;
  end

endmodule

>>> rtl/slr_step.sv
// One Bresenham step: error update and coordinate stepping.
// Depends on slr_pkg.
module slr_step #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0] cur_x,
  input  logic [COORD_BITS-1:0] cur_y,
  input  logic [COORD_BITS-1:0] major_len,
  input  logic [COORD_BITS-1:0] minor_len,
  input  logic [COORD_BITS:0]   error_acc,
  input  slr_pkg::line_dir_t    dir,
  output logic [COORD_BITS-1:0] next_x,
  output logic [COORD_BITS-1:0] next_y,
  output logic [COORD_BITS:0]   next_err
);
  import slr_pkg::*;

  logic [COORD_BITS:0]   err_sum;
  logic                  minor_step;
  logic [COORD_BITS-1:0] x_moved, y_moved;

  assign err_sum    = error_acc + {1'b0, minor_len};
  assign minor_step = err_sum >= {1'b0, major_len};
  assign next_err   = minor_step ? err_sum - {1'b0, major_len} : err_sum;

  assign x_moved = dir.dir_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
  assign y_moved = dir.dir_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;

  always_comb begin
    if (dir.x_is_major) begin
      next_x = x_moved;
      next_y = minor_step ? y_moved : cur_y;
    end else begin
      next_y = y_moved;
      next_x = minor_step ? x_moved : cur_x;
    end
  end

endmodule

>>> rtl/slr_checker.sv
// Port-level checker for the shaded line rasterizer, bound to the top level.
// Depends on shaded_line_rasterizer_unit_assert.svh.
`include "shaded_line_rasterizer_unit_assert.svh"

module slr_checker #(
  parameter int COORD_BITS  = 12,
  parameter int HEIGHT_BITS = 16,
  localparam int RAMP_BITS   = ((HEIGHT_BITS > 2*COORD_BITS) ? HEIGHT_BITS : 2*COORD_BITS) + 2,
  localparam int OUT_W       = 2*COORD_BITS + HEIGHT_BITS + RAMP_BITS,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tuser,
  input logic                   m_tlast
);

  // items taken in but not yet delivered; the block holds two at most
  logic [1:0] pending;
  logic [1:0] pending_next;

  always_comb begin
    pending_next = pending;
    if (s_tvalid && s_tready) begin
      pending_next = pending_next + 2'd1;
    end
    if (m_tvalid && m_tready) begin
      pending_next = pending_next - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  `SLR_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid, "result valid right after reset")
  `SLR_ASSERT_IMPL(a_empty_result, clk, rst, m_tvalid && !m_tuser, m_tdata == '0 && !m_tlast, "empty result carries data")
  `SLR_ASSERT_IMPL(a_result_owed, clk, rst, m_tvalid, pending != 2'd0, "result with no item pending")
  `SLR_ASSERT_IMPL(a_stall_full, clk, rst, !s_tready, pending == 2'd2, "input stalled while not full")
  `SLR_ASSERT_NEXT(a_hold_stalled, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind shaded_line_rasterizer_unit slr_checker #(
  .COORD_BITS  (COORD_BITS),
  .HEIGHT_BITS (HEIGHT_BITS)
) u_slr_checker (.*);

>>> dv/tb_shaded_line_rasterizer_unit.sv
// Self-checking bench for shaded_line_rasterizer_unit: directed lines, then random lines.
// Pixels come from a local line stepper or a directed row; compared field by field.
// Depends on slr_pkg and the rasterizer RTL.
module tb_shaded_line_rasterizer_unit;
  import slr_pkg::*;

  localparam int IN_TDATA_W     = 64;
  localparam int OUT_TDATA_W    = 72;
  localparam int RANDOM_END     = 1625;
  localparam int STALL_LIMIT    = 2000;
  localparam int HOLD_OFF_LEN   = 100;
  localparam int HOLD_OFF_AT    = 300;
  localparam int DRAIN_AT       = 500;
  localparam int LONG_LINE_AT   = 1200;
  localparam int LONG_LINE_LEN  = 400;

  // one emitted pixel as it leaves the block
  typedef struct packed {
    logic        valid;
    logic [11:0] px;
    logic [11:0] py;
    logic [15:0] base;
    logic [25:0] ramp;
    logic        last;
  } pixel_t;

  typedef struct {
    action_t                act;
    logic [IN_TDATA_W-1:0]  data;
    bit                     known;
    pixel_t                 want;
  } stim_row_t;

  localparam pixel_t NO_PIXEL = '0;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;

  shaded_line_rasterizer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // line stepper state
  logic [11:0] pos_x, pos_y;
  logic [15:0] line_z;
  logic [11:0] len_major, len_minor;
  line_dir_t   dir;
  logic [12:0] err;
  logic [11:0] steps_done;
  logic [23:0] ramp_sum;
  logic        line_on = 1'b0;

  pixel_t    pending_pixels[$];
  stim_row_t stim_rows[$];
  int        items_sent = 0;
  int        lines_started = 0;
  int        pixels_checked = 0;
  int        fail_count = 0;
  int        idle_cycles = 0;
  bit        no_gaps = 1'b0;

  task automatic report_mismatch(string what, logic [OUT_TDATA_W-1:0] got,
                                 logic [OUT_TDATA_W-1:0] want);
    $display("MISMATCH after %0d checked: %s got %0h want %0h",
             pixels_checked, what, got, want);
    fail_count++;
  endtask

  function automatic logic [IN_TDATA_W-1:0] pack_in(int sx, int sy, int sz, int ex, int ey);
    return {ey[11:0], ex[11:0], sz[15:0], sy[11:0], sx[11:0]};
  endfunction

  function automatic stim_row_t line_row(action_t a, int sx, int sy, int sz, int ex, int ey);
    stim_row_t r;
    r.act   = a;
    r.data  = pack_in(sx, sy, sz, ex, ey);
    r.known = 1'b0;
    r.want  = NO_PIXEL;
    return r;
  endfunction

  function automatic stim_row_t known_row(action_t a, int sx, int sy, int sz, int ex, int ey,
                                          pixel_t w);
    stim_row_t r;
    r       = line_row(a, sx, sy, sz, ex, ey);
    r.known = 1'b1;
    r.want  = w;
    return r;
  endfunction

  function automatic pixel_t pixel_at(longint off, bit is_last);
    pixel_t p;
    longint r;
    r      = longint'($signed(line_z)) + off;
    p.valid = 1'b1;
    p.px   = pos_x;
    p.py   = pos_y;
    p.base = line_z;
    p.ramp = r[25:0];
    p.last = is_last;
    return p;
  endfunction

  function automatic pixel_t rasterize(action_t act, logic [IN_TDATA_W-1:0] d);
    int sx, sy, ex, ey, dx, dy, ax, ay;
    bit is_last;
    if (act == ACT_START) begin
      sx = int'($signed(d[11:0]));
      sy = int'($signed(d[23:12]));
      ex = int'($signed(d[51:40]));
      ey = int'($signed(d[63:52]));
      dx = ex - sx;
      dy = ey - sy;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      pos_x = d[11:0];
      pos_y = d[23:12];
      line_z = d[39:24];
      dir.dir_x_neg  = !(dx > 0);
      dir.dir_y_neg  = !(dy > 0);
      dir.x_is_major = ax > ay;   // ties go along y
      len_major = dir.x_is_major ? ax[11:0] : ay[11:0];
      len_minor = dir.x_is_major ? ay[11:0] : ax[11:0];
      err = {1'b0, len_minor};
      steps_done = '0;
      ramp_sum = '0;
      line_on = len_major != 0;
      return pixel_at(1, !line_on);
    end
    if (!line_on)
      return NO_PIXEL;
    // error is raised before the test
    err = err + {1'b0, len_minor};
    if (dir.x_is_major) begin
      pos_x = dir.dir_x_neg ? pos_x - 12'd1 : pos_x + 12'd1;
      if (err >= {1'b0, len_major}) begin
        err = err - {1'b0, len_major};
        pos_y = dir.dir_y_neg ? pos_y - 12'd1 : pos_y + 12'd1;
      end
    end else begin
      pos_y = dir.dir_y_neg ? pos_y - 12'd1 : pos_y + 12'd1;
      if (err >= {1'b0, len_major}) begin
        err = err - {1'b0, len_major};
        pos_x = dir.dir_x_neg ? pos_x - 12'd1 : pos_x + 12'd1;
      end
    end
    steps_done = steps_done + 12'd1;
    is_last = steps_done == len_major;
    pixel_at_ret: begin
      pixel_t p;
      p = pixel_at(longint'(ramp_sum), is_last);
      ramp_sum = ramp_sum + {12'd0, len_major};
      if (is_last)
        line_on = 1'b0;
      return p;
    end
  endfunction

  task automatic send_item(action_t act, logic [IN_TDATA_W-1:0] d, bit known, pixel_t want);
    pixel_t p;
    while (!no_gaps && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    p = rasterize(act, d);
    pending_pixels.push_back(known ? want : p);
    items_sent++;
    if (act == ACT_START)
      lines_started++;
  endtask

  // stimulus
  initial begin
    int sx, sy, sz, ex, ey, ax, ay, len, n, pick, span;
    bit drained, long_done;
    drained = 1'b0;
    long_done = 1'b0;

    stim_rows.push_back(known_row(ACT_STEP, 0, 0, 0, 0, 0, NO_PIXEL));
    stim_rows.push_back(known_row(ACT_START, 0, 0, 0, 0, 0,
                                  '{1'b1, 12'h000, 12'h000, 16'h0000, 26'h0000001, 1'b1}));
    stim_rows.push_back(known_row(ACT_STEP, 5, 5, 5, 5, 5, NO_PIXEL));
    // full diagonal, a tie between the deltas
    stim_rows.push_back(known_row(ACT_START, -2048, -2048, -32768, 2047, 2047,
                                  '{1'b1, 12'h800, 12'h800, 16'h8000, 26'h3FF8001, 1'b0}));
    stim_rows.push_back(line_row(ACT_STEP, -1, -1, -1, -1, -1));
    stim_rows.push_back(line_row(ACT_STEP, 0, 0, 0, 0, 0));
    // restart mid line
    stim_rows.push_back(known_row(ACT_START, 2047, 2047, 32767, -2048, -2048,
                                  '{1'b1, 12'h7FF, 12'h7FF, 16'h7FFF, 26'h0008000, 1'b0}));
    stim_rows.push_back(line_row(ACT_STEP, 0, 0, 0, 0, 0));
    stim_rows.push_back(line_row(ACT_START, 5, 5, 100, 9, 7));
    repeat (4) stim_rows.push_back(line_row(ACT_STEP, 1, 2, 3, 4, 5));
    stim_rows.push_back(known_row(ACT_STEP, 0, 0, 0, 0, 0, NO_PIXEL));
    stim_rows.push_back(line_row(ACT_START, 0, 0, -1, 2, -5));
    repeat (5) stim_rows.push_back(line_row(ACT_STEP, 0, 0, 0, 0, 0));
    stim_rows.push_back(line_row(ACT_START, 3, 3, 7, 0, 3));
    repeat (3) stim_rows.push_back(line_row(ACT_STEP, -1, -1, -1, -1, -1));
    stim_rows.push_back(known_row(ACT_START, -1, -1, 0, -1, -1,
                                  '{1'b1, 12'hFFF, 12'hFFF, 16'h0000, 26'h0000001, 1'b1}));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i])
      send_item(stim_rows[i].act, stim_rows[i].data, stim_rows[i].known, stim_rows[i].want);

    while (items_sent < RANDOM_END) begin
      no_gaps = (items_sent >= 700) && (items_sent < 1000);
      if (!drained && items_sent >= DRAIN_AT) begin
        drained = 1'b1;
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
          @(posedge clk);
        @(posedge clk);
      end
      pick = $urandom_range(99);
      if (!long_done && items_sent >= LONG_LINE_AT) begin
        // long x-major line from the corner, walked to its end and one step past
        long_done = 1'b1;
        sz = 32767 - $urandom_range(200);
        send_item(ACT_START, pack_in(-2048, -2048, sz, -2048 + LONG_LINE_LEN, -1849),
                  1'b0, NO_PIXEL);
        repeat (LONG_LINE_LEN + 1) send_item(ACT_STEP, {$urandom, $urandom}, 1'b0, NO_PIXEL);
      end else if (pick < 12) begin
        repeat ($urandom_range(1, 4))
          send_item(action_t'($urandom_range(1)), {$urandom, $urandom}, 1'b0, NO_PIXEL);
      end else begin
        span = (pick < 22) ? 60 : ((pick < 28) ? 4095 : 8);
        sx = int'($urandom_range(4095)) - 2048;
        sy = int'($urandom_range(4095)) - 2048;
        sz = int'($urandom_range(65535)) - 32768;
        ex = sx + int'($urandom_range(2 * span)) - span;
        ey = sy + int'($urandom_range(2 * span)) - span;
        if (ex > 2047) ex = 2047;
        if (ex < -2048) ex = -2048;
        if (ey > 2047) ey = 2047;
        if (ey < -2048) ey = -2048;
        ax = (ex > sx) ? ex - sx : sx - ex;
        ay = (ey > sy) ? ey - sy : sy - ey;
        len = (ax > ay) ? ax : ay;
        if (span == 4095)
          n = $urandom_range(30);
        else if ($urandom_range(99) < 80)
          n = len + $urandom_range(2);
        else
          n = $urandom_range(len);   // cut short, next start drops it
        send_item(ACT_START, pack_in(sx, sy, sz, ex, ey), 1'b0, NO_PIXEL);
        repeat (n) send_item(ACT_STEP, {$urandom, $urandom}, 1'b0, NO_PIXEL);
      end
    end
    s_tvalid <= 1'b0;
    no_gaps = 1'b0;

    while (pending_pixels.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d items over %0d line starts, incl. a %0d-step line and restarts",
             items_sent, lines_started, LONG_LINE_LEN);
    $display("%0d result items checked, with a %0d-cycle receiver hold-off and a full drain",
             pixels_checked, HOLD_OFF_LEN);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && items_sent >= HOLD_OFF_AT) begin
        held = 1'b1;
        hold_left = HOLD_OFF_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_gaps || ($urandom_range(99) >= 33);
      end
    end
  end

  // result check
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("item with nothing pending", m_tdata, '0);
      end else begin
        want = pending_pixels.pop_front();
        if (m_tuser !== want.valid)
          report_mismatch("valid_res", OUT_TDATA_W'(m_tuser), OUT_TDATA_W'(want.valid));
        if (m_tdata[11:0] !== want.px)
          report_mismatch("pixel_x", OUT_TDATA_W'(m_tdata[11:0]), OUT_TDATA_W'(want.px));
        if (m_tdata[23:12] !== want.py)
          report_mismatch("pixel_y", OUT_TDATA_W'(m_tdata[23:12]), OUT_TDATA_W'(want.py));
        if (m_tdata[39:24] !== want.base)
          report_mismatch("shade_base", OUT_TDATA_W'(m_tdata[39:24]), OUT_TDATA_W'(want.base));
        if (m_tdata[65:40] !== want.ramp)
          report_mismatch("shade_ramp", OUT_TDATA_W'(m_tdata[65:40]), OUT_TDATA_W'(want.ramp));
        if (m_tdata[71:66] !== 6'd0)
          report_mismatch("tdata padding", OUT_TDATA_W'(m_tdata[71:66]), '0);
        if (m_tlast !== want.last)
          report_mismatch("last", OUT_TDATA_W'(m_tlast), OUT_TDATA_W'(want.last));
        pixels_checked++;
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
        $display("no item moved for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
